// ===== hw/rtl/lseq_pkg.sv =====
`default_nettype none

package lseq_pkg;

    // field widths fixed by the interface
    localparam int HGT_W      = 17;
    localparam int STEP_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register reset values, quarter millimetres
    localparam logic [HGT_W-1:0]  INIT_HEIGHT_RST   = 17'd12000;
    localparam logic [STEP_W-1:0] DESCENT_STEP_RST  = 10'd30;
    localparam logic [HGT_W-1:0]  CENTER_RADIUS_RST = 17'd1200;
    localparam logic [HGT_W-1:0]  TARGET_RADIUS_RST = 17'd1200;
    localparam logic [HGT_W-1:0]  DISARM_HEIGHT_RST = 17'd2000;

    // landing sequence phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SEARCH   = 4'd1,
        PH_STREAM   = 4'd2,
        PH_OFFB     = 4'd3,
        PH_WAIT     = 4'd4,
        PH_DESC     = 4'd5,
        PH_DISARMED = 4'd6,
        PH_LANDED   = 4'd7,
        PH_KILL     = 4'd8
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_HEIGHT   = 3'd0,
        REG_DESCENT_STEP  = 3'd1,
        REG_CENTER_RADIUS = 3'd2,
        REG_TARGET_RADIUS = 3'd3,
        REG_DISARM_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic kill_key;
        logic start_key;
        logic vehicle_seen;
        logic offboard_ok;
        logic disarm_ok;
        logic on_ground;
    } flags_t;

    typedef struct packed {
        logic [HGT_W-1:0]  init_height;
        logic [STEP_W-1:0] descent_step;
        logic [HGT_W-1:0]  center_radius;
        logic [HGT_W-1:0]  target_radius;
        logic [HGT_W-1:0]  disarm_height;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic             streaming;
        logic [HGT_W-1:0] target_height;
        logic             request_offboard;
        logic             request_disarm;
        logic             finished;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lseq_cfg.sv =====
`default_nettype none

module lseq_cfg
    import lseq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_INIT_HEIGHT:   cfg_next.init_height   = cfg_wdata[HGT_W-1:0];
                REG_DESCENT_STEP:  cfg_next.descent_step  = cfg_wdata[STEP_W-1:0];
                REG_CENTER_RADIUS: cfg_next.center_radius = cfg_wdata[HGT_W-1:0];
                REG_TARGET_RADIUS: cfg_next.target_radius = cfg_wdata[HGT_W-1:0];
                REG_DISARM_HEIGHT: cfg_next.disarm_height = cfg_wdata[HGT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.init_height   <= INIT_HEIGHT_RST;
            cfg_reg.descent_step  <= DESCENT_STEP_RST;
            cfg_reg.center_radius <= CENTER_RADIUS_RST;
            cfg_reg.target_radius <= TARGET_RADIUS_RST;
            cfg_reg.disarm_height <= DISARM_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lseq_in_stage.sv =====
`default_nettype none

module lseq_in_stage
    import lseq_pkg::*;
#(
    parameter int POS_BITS = 18
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  flags_t                          s_flags,
    input  wire logic signed [POS_BITS-1:0] s_pos_x,
    input  wire logic signed [POS_BITS-1:0] s_pos_y,
    input  wire logic signed [POS_BITS-1:0] s_pos_z,
    input  wire logic                       take,
    output logic                            q_valid,
    output flags_t                          q_flags,
    output logic signed [POS_BITS-1:0]      q_pos_x,
    output logic signed [POS_BITS-1:0]      q_pos_y,
    output logic signed [POS_BITS-1:0]      q_pos_z
);

    logic                       valid_reg;
    logic                       valid_next;
    flags_t                     flags_reg;
    logic signed [POS_BITS-1:0] pos_x_reg;
    logic signed [POS_BITS-1:0] pos_y_reg;
    logic signed [POS_BITS-1:0] pos_z_reg;

    // room when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            flags_reg <= s_flags;
            pos_x_reg <= s_pos_x;
            pos_y_reg <= s_pos_y;
            pos_z_reg <= s_pos_z;
        end
    end

    assign q_valid = valid_reg;
    assign q_flags = flags_reg;
    assign q_pos_x = pos_x_reg;
    assign q_pos_y = pos_y_reg;
    assign q_pos_z = pos_z_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lseq_step.sv =====
`default_nettype none

module lseq_step
    import lseq_pkg::*;
#(
    parameter int POS_BITS = 18
) (
    input  cfg_t                            cfg,
    input  flags_t                          flags,
    input  wire logic signed [POS_BITS-1:0] pos_x,
    input  wire logic signed [POS_BITS-1:0] pos_y,
    input  wire logic signed [POS_BITS-1:0] pos_z,
    input  phase_t                          phase_cur,
    input  wire logic [HGT_W-1:0]           target_cur,
    input  wire logic                       stream_cur,
    output phase_t                          phase_next,
    output logic [HGT_W-1:0]                target_next,
    output logic                            stream_next,
    output res_t                            res
);

    // signed width that holds both a position and a 17-bit height
    localparam int EW  = ((POS_BITS > HGT_W) ? POS_BITS : HGT_W) + 1;
    localparam int XYW = 2 * POS_BITS + 1;
    localparam int R2W = 2 * HGT_W;
    localparam int SW  = ((XYW > 2 * EW) ? XYW : 2 * EW) + 1;
    localparam int CW  = (XYW > R2W) ? XYW : R2W;

    logic [POS_BITS-1:0]   abs_x;
    logic [POS_BITS-1:0]   abs_y;
    logic [2*POS_BITS-1:0] sq_x;
    logic [2*POS_BITS-1:0] sq_y;
    logic [XYW-1:0]        xy2;
    logic signed [EW-1:0]  pz_e;
    logic signed [EW:0]    dz_s;
    logic [EW-1:0]         abs_dz;
    logic [2*EW-1:0]       sq_dz;
    logic [SW-1:0]         dist2;
    logic [R2W-1:0]        target_r2;
    logic [R2W-1:0]        center_r2;
    logic                  below_init;
    logic                  below_disarm;
    logic                  near_target;
    logic                  near_center;
    phase_t                phase_act;

    // horizontal distance squared
    assign abs_x = pos_x[POS_BITS-1] ? POS_BITS'(-pos_x) : POS_BITS'(pos_x);
    assign abs_y = pos_y[POS_BITS-1] ? POS_BITS'(-pos_y) : POS_BITS'(pos_y);
    assign sq_x  = abs_x * abs_x;
    assign sq_y  = abs_y * abs_y;
    assign xy2   = XYW'(sq_x) + XYW'(sq_y);

    // vertical distance to the current target
    assign pz_e   = EW'(pos_z);
    assign dz_s   = (EW+1)'($signed({1'b0, target_cur})) - (EW+1)'(pz_e);
    assign abs_dz = dz_s[EW] ? EW'(-dz_s) : EW'(dz_s);
    assign sq_dz  = abs_dz * abs_dz;
    assign dist2  = SW'(xy2) + SW'(sq_dz);

    assign target_r2 = cfg.target_radius * cfg.target_radius;
    assign center_r2 = cfg.center_radius * cfg.center_radius;

    // threshold compares, negative heights fall below everything
    assign below_init   = pz_e < $signed(EW'(cfg.init_height));
    assign below_disarm = pz_e < $signed(EW'(cfg.disarm_height));
    assign near_target  = dist2 < SW'(target_r2);
    assign near_center  = CW'(xy2) < CW'(center_r2);

    // phase transitions and per-tick outputs
    always_comb begin
        phase_act = (phase_cur != PH_LANDED && flags.kill_key) ? PH_KILL : phase_cur;
        phase_next  = phase_act;
        target_next = target_cur;
        stream_next = stream_cur;
        res = '0;
        unique case (phase_act)
            PH_SEARCH: begin
                if (flags.vehicle_seen) begin
                    phase_next = PH_STREAM;
                end
            end
            PH_STREAM: begin
                target_next = below_init ? cfg.init_height : pz_e[HGT_W-1:0];
                stream_next = 1'b1;
                phase_next  = PH_OFFB;
            end
            PH_OFFB: begin
                res.request_offboard = 1'b1;
                if (flags.offboard_ok) begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (near_target) begin
                    phase_next = PH_DESC;
                end
            end
            PH_DESC: begin
                if (below_disarm) begin
                    res.request_disarm = 1'b1;
                    if (flags.disarm_ok) begin
                        phase_next = PH_DISARMED;
                    end
                end else if (near_center) begin
                    target_next = (target_cur > HGT_W'(cfg.descent_step))
                                ? target_cur - HGT_W'(cfg.descent_step) : '0;
                end else begin
                    phase_next = PH_WAIT;
                end
            end
            PH_DISARMED: begin
                if (flags.on_ground) begin
                    phase_next = PH_LANDED;
                end
            end
            PH_LANDED: begin
                res.finished = 1'b1;
            end
            PH_KILL: begin
                res.request_disarm = 1'b1;
            end
            default: begin
                phase_act  = PH_IDLE;
                phase_next = flags.start_key ? PH_SEARCH : PH_IDLE;
            end
        endcase
        res.phase         = phase_act;
        res.streaming     = (phase_act == PH_LANDED) ? 1'b0 : stream_next;
        res.target_height = target_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/landing_sequencer_top.sv =====
// path: a word is accepted into the input register, passes the combinational step
// logic and loads the result register once that register is free or draining
// throughput: one word per cycle unless m_ready stalls the result register
// reset: phase idle, target height zero, stream off, registers at their defaults
// no clearing pass; input is taken on the first cycle after reset
`default_nettype none

module landing_sequencer_top
    import lseq_pkg::*;
#(
    parameter int POS_BITS = 18
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kill_key,
    input  wire logic                       s_start_key,
    input  wire logic                       s_vehicle_seen,
    input  wire logic                       s_offboard_ok,
    input  wire logic                       s_disarm_ok,
    input  wire logic                       s_on_ground,
    input  wire logic signed [POS_BITS-1:0] s_pos_x,
    input  wire logic signed [POS_BITS-1:0] s_pos_y,
    input  wire logic signed [POS_BITS-1:0] s_pos_z,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [3:0]                      m_phase,
    output logic                            m_streaming,
    output logic [HGT_W-1:0]                m_target_height,
    output logic                            m_request_offboard,
    output logic                            m_request_disarm,
    output logic                            m_finished
);

    cfg_t                       cfg;
    flags_t                     s_flags;
    flags_t                     q_flags;
    logic                       q_valid;
    logic signed [POS_BITS-1:0] q_pos_x;
    logic signed [POS_BITS-1:0] q_pos_y;
    logic signed [POS_BITS-1:0] q_pos_z;
    logic                       step_fire;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [HGT_W-1:0] target_reg;
    logic [HGT_W-1:0] target_next;
    logic             stream_reg;
    logic             stream_next;
    res_t             res_next;
    res_t             res_reg;
    logic             m_valid_reg;
    logic             m_valid_next;

    lseq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_flags = '{kill_key:     s_kill_key,
                       start_key:    s_start_key,
                       vehicle_seen: s_vehicle_seen,
                       offboard_ok:  s_offboard_ok,
                       disarm_ok:    s_disarm_ok,
                       on_ground:    s_on_ground};

    lseq_in_stage #(.POS_BITS(POS_BITS)) u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_flags (s_flags),
        .s_pos_x (s_pos_x),
        .s_pos_y (s_pos_y),
        .s_pos_z (s_pos_z),
        .take    (step_fire),
        .q_valid (q_valid),
        .q_flags (q_flags),
        .q_pos_x (q_pos_x),
        .q_pos_y (q_pos_y),
        .q_pos_z (q_pos_z)
    );

    lseq_step #(.POS_BITS(POS_BITS)) u_step (
        .cfg         (cfg),
        .flags       (q_flags),
        .pos_x       (q_pos_x),
        .pos_y       (q_pos_y),
        .pos_z       (q_pos_z),
        .phase_cur   (phase_reg),
        .target_cur  (target_reg),
        .stream_cur  (stream_reg),
        .phase_next  (phase_next),
        .target_next (target_next),
        .stream_next (stream_next),
        .res         (res_next)
    );

    // a held word steps when the result register is free or draining
    assign step_fire = q_valid && (!m_valid_reg || m_ready);

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            target_reg <= '0;
            stream_reg <= 1'b0;
        end else if (step_fire) begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            stream_reg <= stream_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_phase            = res_reg.phase;
    assign m_streaming        = res_reg.streaming;
    assign m_target_height    = res_reg.target_height;
    assign m_request_offboard = res_reg.request_offboard;
    assign m_request_disarm   = res_reg.request_disarm;
    assign m_finished         = res_reg.finished;

    // kill and landed are terminal
    a_kill_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_KILL |=> phase_reg == PH_KILL)
        else $error("kill phase left");

    a_landed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LANDED |=> phase_reg == PH_LANDED)
        else $error("landed phase left");

    // once the stream starts it never stops
    a_stream_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stream_reg |=> stream_reg)
        else $error("stream dropped");

    // landed word reports finished with no stream
    a_landed_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == PH_LANDED |-> m_finished && !m_streaming)
        else $error("landed word malformed");

    // offboard request only comes from the offboard phase
    a_offb_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_request_offboard |-> m_phase == PH_OFFB)
        else $error("offboard request outside offboard phase");

endmodule

`default_nettype wire
